// ----- hdl/alt_pkg.sv -----
`default_nettype none

package alt_pkg;

  // default line limit; columns and lengths saturate one below it, at most 255
  localparam int MAX_LINE_LEN_DEF = 256;

  // result queue depth; two free slots are needed to take an item
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // token kinds
  localparam logic [2:0] KIND_REGULAR = 3'd0;
  localparam logic [2:0] KIND_NUMERIC = 3'd1;
  localparam logic [2:0] KIND_COMMA   = 3'd2;
  localparam logic [2:0] KIND_OPEN    = 3'd3;
  localparam logic [2:0] KIND_CLOSE   = 3'd4;
  localparam logic [2:0] KIND_PLUS    = 3'd5;
  localparam logic [2:0] KIND_MINUS   = 3'd6;
  localparam logic [2:0] KIND_EOL     = 3'd7;

  // number base of the open word
  typedef logic [1:0] base_t;
  localparam base_t BASE_DEC = 2'd0;
  localparam base_t BASE_BIN = 2'd1;
  localparam base_t BASE_HEX = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_LBRK   = 8'h5b;
  localparam logic [7:0] CH_RBRK   = 8'h5d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;

  // one result
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] start;
    logic [7:0] length;
    logic       times;
  } tok_t;

  // results produced by one accepted request
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       tok0;
    tok_t       tok1;
  } push_t;

  // queue status seen by the top level
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              room2;
  } qstat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic digit_ok(input logic [7:0] c, input base_t b);
    logic dec;
    dec = (c >= CH_ZERO) && (c <= CH_NINE);
    if (b == BASE_BIN) begin
      return (c == CH_ZERO) || (c == CH_ONE);
    end
    return dec || ((b == BASE_HEX) && (c >= CH_A) && (c <= CH_F));
  endfunction

endpackage

`default_nettype wire

// ----- hdl/alt_step.sv -----
`default_nettype none

module alt_step #(
  parameter int MAX_LINE_LEN = alt_pkg::MAX_LINE_LEN_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire logic [7:0]   char_code,
  input  wire logic         line_end,
  output alt_pkg::push_t    push
);
  import alt_pkg::*;

  localparam int CAP = ((MAX_LINE_LEN - 1) > 255) ? 255 : (MAX_LINE_LEN - 1);
  localparam logic [7:0] CAP_V = 8'(CAP);

  // line scanner state
  logic       in_comment_r, in_comment_nxt;
  logic       in_word_r, in_word_nxt;
  logic [7:0] column_r, column_nxt;
  logic [7:0] wstart_r, wstart_nxt;
  logic [7:0] wlen_r, wlen_nxt;
  base_t      base_r, base_nxt;
  logic       fzero_r, fzero_nxt;
  logic       numeric_r, numeric_nxt;

  logic [7:0] col_inc;
  logic [7:0] len_inc;
  tok_t       word_tok;
  tok_t       second_tok;
  logic       have_second;
  logic [2:0] punct_kind;
  logic       punct_hit;
  logic       star;

  assign col_inc = (column_r >= CAP_V) ? CAP_V : column_r + 8'd1;
  assign len_inc = (wlen_r >= CAP_V) ? CAP_V : wlen_r + 8'd1;

  // open word as a result
  always_comb begin
    word_tok.kind   = numeric_r ? KIND_NUMERIC : KIND_REGULAR;
    word_tok.start  = wstart_r;
    word_tok.length = wlen_r;
    word_tok.times  = 1'b0;
  end

  // punctuation decode
  always_comb begin
    punct_hit  = 1'b1;
    punct_kind = KIND_REGULAR;
    star       = 1'b0;
    unique case (char_code)
      CH_COLON, CH_COMMA: punct_kind = KIND_COMMA;
      CH_LBRK:            punct_kind = KIND_OPEN;
      CH_RBRK:            punct_kind = KIND_CLOSE;
      CH_PLUS:            punct_kind = KIND_PLUS;
      CH_MINUS:           punct_kind = KIND_MINUS;
      CH_STAR:            star       = 1'b1;
      default:            punct_hit  = 1'b0;
    endcase
  end

  // next state and results of one request
  always_comb begin
    in_comment_nxt = in_comment_r;
    in_word_nxt    = in_word_r;
    column_nxt     = col_inc;
    wstart_nxt     = wstart_r;
    wlen_nxt       = wlen_r;
    base_nxt       = base_r;
    fzero_nxt      = fzero_r;
    numeric_nxt    = numeric_r;
    have_second    = 1'b0;
    second_tok     = '0;
    // a closing step flushes the word; a line end also emits end of line
    if (line_end) begin
      have_second       = 1'b1;
      second_tok.kind   = KIND_EOL;
      second_tok.start  = column_r;
      second_tok.length = 8'd0;
      second_tok.times  = 1'b0;
      in_comment_nxt    = 1'b0;
      column_nxt        = 8'd0;
    end else if (in_comment_r) begin
      // comment text only moves the column
    end else if (char_code == CH_SEMI) begin
      in_comment_nxt = 1'b1;
    end else if (is_space(char_code)) begin
      // separator only
    end else if (punct_hit) begin
      have_second       = 1'b1;
      second_tok.kind   = punct_kind;
      second_tok.start  = column_r;
      second_tok.length = 8'd1;
      second_tok.times  = star;
    end else if (!in_word_r) begin
      // first character of a word
      in_word_nxt = 1'b1;
      wstart_nxt  = column_r;
      wlen_nxt    = 8'd1;
      base_nxt    = BASE_DEC;
      fzero_nxt   = (char_code == CH_ZERO);
      numeric_nxt = (char_code == CH_UNDER) || digit_ok(char_code, BASE_DEC);
    end else begin
      // second character after a leading zero selects the base
      if ((wlen_r == 8'd1) && fzero_r) begin
        if (char_code == CH_B) begin
          base_nxt = BASE_BIN;
        end else if (char_code == CH_X) begin
          base_nxt = BASE_HEX;
        end else begin
          numeric_nxt = 1'b0;
        end
      end else if ((char_code != CH_UNDER) && !digit_ok(char_code, base_r)) begin
        numeric_nxt = 1'b0;
      end
      wlen_nxt = len_inc;
    end

    // everything but a word character or comment text closes the word
    if (line_end || (!in_comment_r && (char_code == CH_SEMI || is_space(char_code)
        || punct_hit))) begin
      in_word_nxt = 1'b0;
      wstart_nxt  = 8'd0;
      wlen_nxt    = 8'd0;
      base_nxt    = BASE_DEC;
      fzero_nxt   = 1'b0;
      numeric_nxt = 1'b1;
    end
  end

  // word result first, then the second result
  logic closes;
  assign closes = in_word_r && !in_word_nxt;

  always_comb begin
    push.cnt  = {1'b0, closes} + {1'b0, have_second};
    push.tok0 = closes ? word_tok : second_tok;
    push.tok1 = second_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_comment_r <= 1'b0;
      in_word_r    <= 1'b0;
      column_r     <= 8'd0;
      wstart_r     <= 8'd0;
      wlen_r       <= 8'd0;
      base_r       <= BASE_DEC;
      fzero_r      <= 1'b0;
      numeric_r    <= 1'b1;
    end else if (accept) begin
      in_comment_r <= in_comment_nxt;
      in_word_r    <= in_word_nxt;
      column_r     <= column_nxt;
      wstart_r     <= wstart_nxt;
      wlen_r       <= wlen_nxt;
      base_r       <= base_nxt;
      fzero_r      <= fzero_nxt;
      numeric_r    <= numeric_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/alt_outq.sv -----
`default_nettype none

module alt_outq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push_en,
  input  wire alt_pkg::push_t push,
  input  wire logic        pop,
  output alt_pkg::tok_t    head,
  output alt_pkg::qstat_t  stat
);
  import alt_pkg::*;

  tok_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [1:0]        n_in;
  logic [QPTR_W-1:0] wr_ptr_p1;

  assign n_in      = push_en ? push.cnt : 2'd0;
  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(n_in);
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(n_in) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // up to two entries written per request
  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      slot_r[wr_ptr_r] <= push.tok0;
    end
    if (n_in == 2'd2) begin
      slot_r[wr_ptr_p1] <= push.tok1;
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.room2 = (count_r <= QCNT_W'(QDEPTH - 2));

endmodule

`default_nettype wire

// ----- hdl/asm_line_tokenizer_core.sv -----
`default_nettype none

// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    in_char_code, in_line_end
// out_     output     out_valid / out_ready  out_token_kind, out_token_start,
//                                            out_token_length, out_times_sign
//
// One character per cycle while in_ready is high: the scanner state updates
// in the cycle a request is accepted and its zero, one or two results enter
// a four-entry queue. A request is taken whenever the queue has two free
// slots, so a stalled output side backs up into in_ready only once the
// queue holds three results. Results leave on out_ in request order, a
// request's word result first. Reset (rst_n low, synchronous) empties the
// queue and returns the scanner to the start of a line.

module asm_line_tokenizer_core #(
  parameter int MAX_LINE_LEN = alt_pkg::MAX_LINE_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output wire logic       in_ready,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_line_end,
  output wire logic       out_valid,
  input  wire logic       out_ready,
  output wire logic [2:0] out_token_kind,
  output wire logic [7:0] out_token_start,
  output wire logic [7:0] out_token_length,
  output wire logic       out_times_sign
);
  import alt_pkg::*;

  push_t  push;
  tok_t   head;
  qstat_t qstat;
  logic   in_acc;
  logic   out_acc;

  assign in_ready  = qstat.room2;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (qstat.count != '0);
  assign out_acc   = out_valid && out_ready;

  alt_step #(
    .MAX_LINE_LEN(MAX_LINE_LEN)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .char_code (in_char_code),
    .line_end  (in_line_end),
    .push      (push)
  );

  alt_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_en (in_acc),
    .push    (push),
    .pop     (out_acc),
    .head    (head),
    .stat    (qstat)
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_times_sign   = head.times;

  // queue never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  // a line end always leaves a result waiting
  a_eol_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_line_end |=> out_valid)
    else $error("line end produced no result");

  // an empty queue always takes a request
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("empty queue refuses a request");

  // a request never yields more than two results
  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> push.cnt != 2'd3)
    else $error("too many results for one request");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import alt_pkg::*;

  localparam logic [7:0] LINE_CAP =
    (MAX_LINE_LEN_DEF - 1 > 255) ? 8'd255 : 8'(MAX_LINE_LEN_DEF - 1);
  localparam int STUCK_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;
  localparam int RANDOM_REQS = 1100;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  wire        in_ready;
  logic [7:0] in_char_code = 8'h00;
  logic       in_line_end = 1'b0;
  wire        out_valid;
  logic       out_ready = 1'b0;
  wire  [2:0] out_token_kind;
  wire  [7:0] out_token_start;
  wire  [7:0] out_token_length;
  wire        out_times_sign;

  asm_line_tokenizer_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_line_end      (in_line_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_times_sign   (out_times_sign)
  );

  always #10 clk = ~clk;

  // expected tokens, oldest first
  tok_t tok_q[$];
  int   mismatch_cnt = 0;
  int   stuck_cycles = 0;
  int   req_sent = 0;

  // idling controls
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;
  bit   long_hold_req = 1'b0;
  int   rx_stall = 0;

  // scanner state mirrored by the predictor
  bit         sc_comment;
  bit         sc_word;
  logic [7:0] sc_col;
  logic [7:0] sc_wstart;
  logic [7:0] sc_wlen;
  base_t      sc_base;
  bit         sc_lead0;
  bit         sc_numeric;

  // line under construction for the random part
  logic [7:0] line_buf[$];

  function automatic logic [7:0] bump(input logic [7:0] v);
    return (v >= LINE_CAP) ? LINE_CAP : v + 8'd1;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit fits_base(input logic [7:0] c, input base_t b);
    bit dec;
    dec = (c >= CH_ZERO) && (c <= CH_NINE);
    case (b)
      BASE_BIN: return (c == CH_ZERO) || (c == CH_ONE);
      BASE_HEX: return dec || (c >= CH_A && c <= CH_F);
      default:  return dec;
    endcase
  endfunction

  task automatic push_tok(input logic [2:0] k, input logic [7:0] s,
                          input logic [7:0] n, input logic t);
    tok_t tk;
    tk.kind   = k;
    tk.start  = s;
    tk.length = n;
    tk.times  = t;
    tok_q = {tok_q, tk};
  endtask

  // append one byte to the line under construction
  task automatic add_byte(input logic [7:0] c);
    line_buf = {line_buf, c};
  endtask

  task automatic drop_word();
    sc_word    = 1'b0;
    sc_wstart  = 8'd0;
    sc_wlen    = 8'd0;
    sc_base    = BASE_DEC;
    sc_lead0   = 1'b0;
    sc_numeric = 1'b1;
  endtask

  task automatic clear_scanner();
    sc_comment = 1'b0;
    sc_col     = 8'd0;
    drop_word();
  endtask

  // report the open word, if any
  task automatic close_word();
    if (sc_word) begin
      push_tok(sc_numeric ? KIND_NUMERIC : KIND_REGULAR, sc_wstart, sc_wlen, 1'b0);
      drop_word();
    end
  endtask

  task automatic grow_word(input logic [7:0] c);
    if (!sc_word) begin
      sc_word    = 1'b1;
      sc_wstart  = sc_col;
      sc_wlen    = 8'd1;
      sc_base    = BASE_DEC;
      sc_lead0   = (c == CH_ZERO);
      sc_numeric = (c == CH_UNDER) || fits_base(c, BASE_DEC);
    end else begin
      // second char after a leading zero picks the base
      if (sc_wlen == 8'd1 && sc_lead0) begin
        if (c == CH_B) sc_base = BASE_BIN;
        else if (c == CH_X) sc_base = BASE_HEX;
        else sc_numeric = 1'b0;
      end else if (c != CH_UNDER && !fits_base(c, sc_base)) begin
        sc_numeric = 1'b0;
      end
      sc_wlen = bump(sc_wlen);
    end
  endtask

  // expected tokens for one accepted request
  task automatic predict_tokens(input logic [7:0] c, input logic eol);
    logic [2:0] pk;
    logic       star;
    bit         punct;
    if (eol) begin
      close_word();
      push_tok(KIND_EOL, sc_col, 8'd0, 1'b0);
      clear_scanner();
    end else if (sc_comment) begin
      sc_col = bump(sc_col);
    end else begin
      punct = 1'b1;
      star  = 1'b0;
      pk    = KIND_REGULAR;
      case (c)
        CH_COLON, CH_COMMA: pk = KIND_COMMA;
        CH_LBRK:            pk = KIND_OPEN;
        CH_RBRK:            pk = KIND_CLOSE;
        CH_PLUS:            pk = KIND_PLUS;
        CH_MINUS:           pk = KIND_MINUS;
        CH_STAR:            star = 1'b1;
        default:            punct = 1'b0;
      endcase
      if (c == CH_SEMI) begin
        close_word();
        sc_comment = 1'b1;
      end else if (is_blank(c)) begin
        close_word();
      end else if (punct) begin
        close_word();
        push_tok(pk, sc_col, 8'd1, star);
      end else begin
        grow_word(c);
      end
      sc_col = bump(sc_col);
    end
  endtask

  initial clear_scanner();

  // predict on every accepted request
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_tokens(in_char_code, in_line_end);
  end

  // compare every accepted token with the oldest expectation
  always @(posedge clk) begin : check_tokens
    tok_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tok_q.size() == 0) begin
        $error("unexpected token: kind %0d start %0d length %0d times %0d",
               out_token_kind, out_token_start, out_token_length, out_times_sign);
        mismatch_cnt++;
      end else begin
        want = tok_q.pop_front();
        if (out_token_kind !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, out_token_kind);
          mismatch_cnt++;
        end
        if (out_token_start !== want.start) begin
          $error("token_start: expected %0d, got %0d", want.start, out_token_start);
          mismatch_cnt++;
        end
        if (out_token_length !== want.length) begin
          $error("token_length: expected %0d, got %0d", want.length, out_token_length);
          mismatch_cnt++;
        end
        if (out_times_sign !== want.times) begin
          $error("times_sign: expected %0d, got %0d", want.times, out_times_sign);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog: no handshake on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // token sink: random stalls, occasional long hold-off on request
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_stall = LONG_HOLD;
    end
    if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else if (rx_calm || $urandom_range(0, 99) < 60) begin
      out_ready <= 1'b1;
    end else begin
      rx_stall = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end
  end

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // offer one request and hold it until accepted
  task automatic send_char(input logic [7:0] c, input logic eol);
    int gap;
    gap = next_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_line_end  <= eol;
    do @(posedge clk); while (!in_ready);
    req_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic send_repeat(input logic [7:0] c, input int n);
    repeat (n) send_char(c, 1'b0);
  endtask

  task automatic end_line();
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] pick(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // random line pieces
  task automatic add_ident();
    add_byte(pick("abcdefghijklmnopqrstuvwxyz._$"));
    repeat ($urandom_range(0, 5)) add_byte(pick("abcdefghrsxyz0123456789_"));
  endtask

  task automatic add_number();
    int n;
    n = $urandom_range(0, 6);
    case ($urandom_range(0, 4))
      0: begin
        add_byte(pick("0123456789_"));
        repeat (n) add_byte(pick("0123456789_"));
      end
      1: begin
        add_byte(CH_ZERO);
        add_byte(CH_B);
        repeat (n) add_byte(pick("01_"));
      end
      2: begin
        add_byte(CH_ZERO);
        add_byte(CH_X);
        repeat (n) add_byte(pick("0123456789abcdef_"));
      end
      3: begin
        // malformed: bad base letter or stray digits
        add_byte(CH_ZERO);
        add_byte(pick("0123456789aBXgz_.bx"));
        repeat (n) add_byte(pick("0123456789abcdefABCDEFgxyz_"));
      end
      default: add_byte(CH_ZERO);
    endcase
  endtask

  task automatic add_blank();
    repeat ($urandom_range(1, 2)) begin
      case ($urandom_range(0, 11))
        0:       add_byte(CH_TAB);
        1:       add_byte(CH_CR);
        2:       add_byte(8'h0a);
        3:       add_byte(8'h0b);
        4:       add_byte(8'h0c);
        default: add_byte(CH_SPACE);
      endcase
    end
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_operand();
    case ($urandom_range(0, 3))
      0: add_ident();
      1: add_number();
      default: begin
        // memory operand
        add_byte(CH_LBRK);
        add_ident();
        repeat ($urandom_range(0, 2)) begin
          add_byte(pick("+-*"));
          if ($urandom_range(0, 3) == 0) add_blank();
          if ($urandom_range(0, 1)) add_number();
          else add_ident();
        end
        add_byte(CH_RBRK);
      end
    endcase
    if ($urandom_range(0, 12) == 0) add_noise();
  endtask

  // one assembly-like line, or now and then pure noise
  task automatic build_line();
    line_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) begin
      add_ident();
      add_byte(CH_COLON);
      if ($urandom_range(0, 1)) add_blank();
    end
    if ($urandom_range(0, 7) != 0) add_ident();
    for (int i = 0; i < $urandom_range(0, 3); i++) begin
      if (i > 0) add_byte(CH_COMMA);
      if (i == 0 || $urandom_range(0, 1)) add_blank();
      add_operand();
    end
    if ($urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 1)) add_blank();
      add_byte(CH_SEMI);
      repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 2) == 0) begin
      add_blank();
    end
  endtask

  // label, every punctuation mark, all number bases, comment, odd bytes
  task automatic test_directed();
    send_text("L:0x_f,[0b12+_]-0*;z");
    end_line();
    send_char(8'h00, 1'b0);
    send_char(8'h0b, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(CH_CR, 1'b0);
    send_text("0x");
    end_line();
    end_line();
  endtask

  // column and length saturation
  task automatic test_long_lines();
    send_repeat(CH_NINE, 270);
    send_char(CH_COMMA, 1'b0);
    send_text("x");
    end_line();
    send_repeat(CH_SPACE, 250);
    send_text("0x");
    send_repeat(CH_F, 40);
    send_char(CH_SEMI, 1'b0);
    repeat (20) send_char(8'($urandom_range(0, 255)), 1'b0);
    end_line();
  endtask

  // sink holds off while requests keep coming, so in_ready must drop
  task automatic test_backpressure();
    string pat;
    pat = "a,[b]+c-d*";
    tx_calm = 1'b1;
    long_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_char(pat[i % pat.len()], 1'b0);
    end_line();
    tx_calm = 1'b0;
  endtask

  task automatic test_random_lines();
    int start_cnt;
    start_cnt = req_sent;
    while (req_sent - start_cnt < RANDOM_REQS) begin
      build_line();
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      foreach (line_buf[i]) send_char(line_buf[i], 1'b0);
      end_line();
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_long_lines();
    test_backpressure();
    test_random_lines();

    @(negedge clk);
    in_valid <= 1'b0;
    while (tok_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/alt_pkg.sv
hdl/alt_step.sv
hdl/alt_outq.sv
hdl/asm_line_tokenizer_core.sv
tb/tb.sv
